[design/clock_time_set_controller_macros.svh]
// Assertion macros for the clock time-set controller.
// Used by design files that carry concurrent checks; clocked on clk_i, reset rst_ni.
`ifndef CLOCK_TIME_SET_CONTROLLER_MACROS_SVH
`define CLOCK_TIME_SET_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define CTSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CTSC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CTSC_ASSERT(label, prop, msg)
`define CTSC_ASSERT_RST(label, prop, msg)
`endif

`endif

[design/ctsc_pkg.sv]
// Package for the clock time-set controller: request types, mode codes, constants.
// No dependencies.
`default_nettype none

package ctsc_pkg;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_VIEW    = 3'd1;
  localparam logic [2:0] MODE_HOURS   = 3'd2;
  localparam logic [2:0] MODE_MINUTES = 3'd3;
  localparam logic [2:0] MODE_SECONDS = 3'd4;

  localparam logic [4:0] HOURS_LAST = 5'd23;
  localparam logic [5:0] MINSEC_LAST = 6'd59;

  localparam logic [15:0] PERIOD_RESET = 16'd1000;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  localparam logic REG_REFRESH_PERIOD = 1'b0;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } ctsc_time_t;

  typedef struct packed {
    logic       view_button;
    logic       next_button;
    logic       edit_button;
    logic       save_event;
    logic [4:0] now_hours;
    logic [5:0] now_minutes;
    logic [5:0] now_seconds;
  } ctsc_in_req_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] edit_hours;
    logic [5:0] edit_minutes;
    logic [5:0] edit_seconds;
    logic       load_time;
    logic [4:0] recent_hours;
    logic [5:0] recent_minutes;
    logic [5:0] recent_seconds;
    logic [4:0] older_hours;
    logic [5:0] older_minutes;
    logic [5:0] older_seconds;
    logic       refresh_display;
  } ctsc_out_req_t;

  typedef struct packed {
    logic view;
    logic next;
    logic edit;
  } ctsc_fire_t;

  typedef struct packed {
    logic       idle;
    logic [2:0] mode_next;
    ctsc_time_t edit_next;
    logic       load;
  } ctsc_fsm_status_t;

endpackage

`default_nettype wire

[design/ctsc_debounce.sv]
// Shift-register button debouncer: fires when the history holds a zero then a full run of ones.
// Depends on nothing; the fire test uses the history before the new sample shifts in.
`default_nettype none

module ctsc_debounce #(
  parameter int unsigned STABLE_SAMPLES = 15
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic sample_i,
  output logic      fire_o
);

  localparam int unsigned HistW = STABLE_SAMPLES + 1;
  localparam logic [HistW-1:0] FirePattern = {1'b0, {STABLE_SAMPLES{1'b1}}};

  logic [HistW-1:0] history_q, history_d;

  assign history_d = {history_q[HistW-2:0], sample_i};
  assign fire_o    = (history_q == FirePattern);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      history_q <= '0;
    end else if (adv_i) begin
      history_q <= history_d;
    end
  end

endmodule

`default_nettype wire

[design/ctsc_mode_fsm.sv]
// Mode machine: idle, view saved, edit hours/minutes/seconds, with the edited time register.
// Depends on ctsc_pkg for mode codes, time limits and status types.
`default_nettype none

module ctsc_mode_fsm (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire ctsc_pkg::ctsc_fire_t  fire_i,
  input  wire ctsc_pkg::ctsc_time_t  now_i,
  output ctsc_pkg::ctsc_fsm_status_t status_o
);

  import ctsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE    = MODE_IDLE,
    ST_VIEW    = MODE_VIEW,
    ST_HOURS   = MODE_HOURS,
    ST_MINUTES = MODE_MINUTES,
    ST_SECONDS = MODE_SECONDS
  } state_e;

  state_e     state_q, state_d;
  logic       capture_q, capture_d;
  ctsc_time_t edit_q, edit_d;
  ctsc_time_t base;
  logic       load;

  always_comb begin
    state_d   = state_q;
    capture_d = capture_q;
    edit_d    = edit_q;
    base      = edit_q;
    load      = 1'b0;
    unique case (state_q)
      ST_VIEW: begin
        if (fire_i.view) state_d = ST_IDLE;
      end
      ST_HOURS, ST_MINUTES, ST_SECONDS: begin
        base      = capture_q ? now_i : edit_q;
        capture_d = 1'b0;
        edit_d    = base;
        if (fire_i.view) begin
          if (state_q == ST_HOURS) begin
            edit_d.hours = (base.hours >= HOURS_LAST) ? '0 : base.hours + 5'd1;
          end else if (state_q == ST_MINUTES) begin
            edit_d.minutes = (base.minutes >= MINSEC_LAST) ? '0 : base.minutes + 6'd1;
          end else begin
            edit_d.seconds = (base.seconds >= MINSEC_LAST) ? '0 : base.seconds + 6'd1;
          end
        end
        // commit wins over field cycling
        if (fire_i.edit) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end else if (fire_i.next) begin
          if (state_q == ST_HOURS)        state_d = ST_MINUTES;
          else if (state_q == ST_MINUTES) state_d = ST_SECONDS;
          else                            state_d = ST_HOURS;
        end
      end
      default: begin
        if (fire_i.edit) begin
          state_d   = ST_HOURS;
          capture_d = 1'b1;
        end else if (fire_i.view) begin
          state_d = ST_VIEW;
        end else begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      capture_q <= 1'b0;
      edit_q    <= '0;
    end else if (adv_i) begin
      state_q   <= state_d;
      capture_q <= capture_d;
      edit_q    <= edit_d;
    end
  end

  assign status_o.idle      = !((state_q == ST_VIEW) || (state_q == ST_HOURS) ||
                                (state_q == ST_MINUTES) || (state_q == ST_SECONDS));
  assign status_o.mode_next = state_d;
  assign status_o.edit_next = edit_d;
  assign status_o.load      = load;

endmodule

`default_nettype wire

[design/clock_time_set_controller.sv]
// Clock time-set controller top level: input register, debouncers, mode machine,
// save history, refresh counter, result register and the refresh period register.
// Depends on ctsc_pkg, ctsc_debounce, ctsc_mode_fsm and the assertion macro header.
//
// Usage: one input request per 1 ms tick on in_req_i (three raw button levels, a save
// event and the live time), handshaked with in_valid_i / in_stall_o. Every request yields
// exactly one result request on out_req_o with out_valid_o / out_stall_i semantics: the
// result is taken at an edge where out_valid_o is high and out_stall_i is low.
// A request accepted into the input register is offered after it has passed the result
// register. Throughput is one request per cycle while the receiver does not stall; the
// tick update is a single pass of logic between the two registers.
// When the receiver stalls, the result holds and the input register still fills once,
// after which in_stall_o rises until the result is taken.
// Reset clears the mode to idle, the button histories, the edited and saved times and the
// refresh count, and sets refresh_period to 1000. The APB port holds refresh_period at
// byte address 0; pready is always high and writes belong to idle periods.
`default_nettype none

module clock_time_set_controller #(
  parameter int unsigned STABLE_SAMPLES = 15
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire ctsc_pkg::ctsc_in_req_t in_req_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output ctsc_pkg::ctsc_out_req_t     out_req_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  import ctsc_pkg::*;

  `include "clock_time_set_controller_macros.svh"

  logic             in_valid_q;
  ctsc_in_req_t     in_req_q;
  logic             out_valid_q;
  ctsc_out_req_t    out_req_q, out_req_d;
  logic             slot_free, adv;
  logic [15:0]      period_q;
  logic [15:0]      count_q, count_d, count_base;
  logic             refresh;
  ctsc_time_t       now, recent_q, recent_d, older_q, older_d;
  ctsc_fire_t       fire;
  ctsc_fsm_status_t fsm_st;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && slot_free;
  assign in_stall_o = in_valid_q && !slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_req_q <= in_req_i;
  end

  assign now.hours   = in_req_q.now_hours;
  assign now.minutes = in_req_q.now_minutes;
  assign now.seconds = in_req_q.now_seconds;

  ctsc_debounce #(.STABLE_SAMPLES(STABLE_SAMPLES)) u_view_db (
    .clk_i, .rst_ni, .adv_i(adv), .sample_i(in_req_q.view_button), .fire_o(fire.view)
  );
  ctsc_debounce #(.STABLE_SAMPLES(STABLE_SAMPLES)) u_next_db (
    .clk_i, .rst_ni, .adv_i(adv), .sample_i(in_req_q.next_button), .fire_o(fire.next)
  );
  ctsc_debounce #(.STABLE_SAMPLES(STABLE_SAMPLES)) u_edit_db (
    .clk_i, .rst_ni, .adv_i(adv), .sample_i(in_req_q.edit_button), .fire_o(fire.edit)
  );

  ctsc_mode_fsm u_fsm (
    .clk_i, .rst_ni, .adv_i(adv), .fire_i(fire), .now_i(now), .status_o(fsm_st)
  );

  assign older_d  = in_req_q.save_event ? recent_q : older_q;
  assign recent_d = in_req_q.save_event ? now : recent_q;

  assign refresh    = fsm_st.idle && (count_q >= period_q);
  assign count_base = refresh ? '0 : count_q;
  assign count_d    = (count_base != COUNT_MAX) ? count_base + 16'd1 : count_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      older_q  <= '0;
      count_q  <= '0;
    end else if (adv) begin
      recent_q <= recent_d;
      older_q  <= older_d;
      count_q  <= count_d;
    end
  end

  always_comb begin
    out_req_d.mode            = fsm_st.mode_next;
    out_req_d.edit_hours      = fsm_st.edit_next.hours;
    out_req_d.edit_minutes    = fsm_st.edit_next.minutes;
    out_req_d.edit_seconds    = fsm_st.edit_next.seconds;
    out_req_d.load_time       = fsm_st.load;
    out_req_d.recent_hours    = recent_d.hours;
    out_req_d.recent_minutes  = recent_d.minutes;
    out_req_d.recent_seconds  = recent_d.seconds;
    out_req_d.older_hours     = older_d.hours;
    out_req_d.older_minutes   = older_d.minutes;
    out_req_d.older_seconds   = older_d.seconds;
    out_req_d.refresh_display = refresh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_req_q <= out_req_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_REFRESH_PERIOD)) begin
      period_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REFRESH_PERIOD) ? {16'd0, period_q} : '0;

  `CTSC_ASSERT(a_load_goes_idle, out_valid_o && out_req_o.load_time |-> out_req_o.mode == MODE_IDLE, "load_time without return to idle")
  `CTSC_ASSERT(a_load_refresh_excl, adv |-> !(fsm_st.load && refresh), "load and refresh in one tick")
  `CTSC_ASSERT(a_refresh_restarts, adv && refresh |=> count_q == 16'd1, "refresh did not restart the count")

endmodule

`default_nettype wire
